### src/arc_pkg.sv
// ============================================================================
// arc_pkg
// Shared types and codes for the acknowledge and retransmit controller.
// ============================================================================
`default_nettype none

package arc_pkg;

  typedef enum logic [1:0] {
    OP_SUBMIT = 2'd0,
    OP_TICK   = 2'd1,
    OP_POLL   = 2'd2,
    OP_RESP   = 2'd3
  } arc_op_e;

  localparam logic [1:0] ST_FREE    = 2'd0;
  localparam logic [1:0] ST_PENDING = 2'd1;
  localparam logic [1:0] ST_AWAIT   = 2'd2;

  localparam logic [7:0] FUNC_ACK_LO   = 8'h01;
  localparam logic [7:0] FUNC_NOACK_LO = 8'h02;
  localparam logic [7:0] FUNC_NOACK_HI = 8'h03;
  localparam logic [7:0] FUNC_ACK_HI   = 8'h04;

  localparam logic [7:0] RESP_OK  = 8'h00;
  localparam logic [7:0] RESP_ERR = 8'h02;

  localparam logic [1:0] CFG_MAX_RETRIES      = 2'd0;
  localparam logic [1:0] CFG_RESPONSE_TIMEOUT = 2'd1;
  localparam logic [1:0] CFG_HEADER_LENGTH    = 2'd2;

  localparam logic [7:0]  RST_MAX_RETRIES      = 8'd3;
  localparam logic [15:0] RST_RESPONSE_TIMEOUT = 16'd100;
  localparam logic [7:0]  RST_HEADER_LENGTH    = 8'd8;

  typedef struct packed {
    logic [7:0]  max_retries;
    logic [15:0] response_timeout;
    logic [7:0]  header_length;
  } arc_cfg_t;

  typedef struct packed {
    arc_op_e     operation;
    logic [7:0]  func_code;
    logic [7:0]  resp_code;
    logic [7:0]  command_code;
    logic [15:0] seq_number;
    logic [7:0]  payload_length;
    logic        link_ok;
  } arc_item_t;

  typedef struct packed {
    logic        accepted;
    logic        send_now;
    logic [7:0]  out_func;
    logic [7:0]  out_resp;
    logic [7:0]  out_command;
    logic [15:0] out_seq;
    logic [8:0]  send_length;
    logic [1:0]  buffer_status;
    logic [7:0]  retries_remaining;
  } arc_result_t;

endpackage

`default_nettype wire

### src/arc_cfg_regs.sv
// ============================================================================
// arc_cfg_regs
// Configuration registers, written through a valid/ready channel.
// ============================================================================
`default_nettype none

module arc_cfg_regs (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              cfg_valid_i,
  output logic                   cfg_ready_o,
  input  wire logic [1:0]        cfg_index_i,
  input  wire logic [15:0]       cfg_data_i,
  output arc_pkg::arc_cfg_t      cfg_o
);
  import arc_pkg::*;

  logic [7:0]  max_retries_q;
  logic [15:0] response_timeout_q;
  logic [7:0]  header_length_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_retries_q      <= RST_MAX_RETRIES;
      response_timeout_q <= RST_RESPONSE_TIMEOUT;
      header_length_q    <= RST_HEADER_LENGTH;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_MAX_RETRIES:      max_retries_q      <= cfg_data_i[7:0];
        CFG_RESPONSE_TIMEOUT: response_timeout_q <= cfg_data_i;
        CFG_HEADER_LENGTH:    header_length_q    <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  assign cfg_o.max_retries      = max_retries_q;
  assign cfg_o.response_timeout = response_timeout_q;
  assign cfg_o.header_length    = header_length_q;

endmodule

`default_nettype wire

### src/arc_core.sv
// ============================================================================
// arc_core
// Buffer state, retry and timeout tracking; computes one result per item.
// ============================================================================
`default_nettype none

module arc_core (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              fire_i,
  input  wire arc_pkg::arc_item_t item_i,
  input  wire arc_pkg::arc_cfg_t  cfg_i,
  output arc_pkg::arc_result_t   result_o
);
  import arc_pkg::*;

  logic [1:0]  status_q, status_d;
  logic        need_ack_q, need_ack_d;
  logic [7:0]  retry_q, retry_d;
  logic [15:0] timeout_q, timeout_d;
  logic        error_q, error_d;
  logic [7:0]  func_q, func_d;
  logic [7:0]  resp_q, resp_d;
  logic [7:0]  command_q, command_d;
  logic [15:0] seq_q, seq_d;
  logic [7:0]  length_q, length_d;
  logic        accepted;
  logic        send_now;

  always_comb begin
    status_d   = status_q;
    need_ack_d = need_ack_q;
    retry_d    = retry_q;
    timeout_d  = timeout_q;
    error_d    = error_q;
    func_d     = func_q;
    resp_d     = resp_q;
    command_d  = command_q;
    seq_d      = seq_q;
    length_d   = length_q;
    accepted   = 1'b0;
    send_now   = 1'b0;
    case (item_i.operation)
      OP_SUBMIT: begin
        if (status_q == ST_FREE) begin
          func_d    = item_i.func_code;
          resp_d    = item_i.resp_code;
          command_d = item_i.command_code;
          seq_d     = item_i.seq_number;
          length_d  = item_i.payload_length;
          if (item_i.func_code inside {FUNC_ACK_LO, FUNC_ACK_HI}) begin
            need_ack_d = 1'b1;
          end else if (item_i.func_code inside {FUNC_NOACK_LO, FUNC_NOACK_HI}) begin
            need_ack_d = 1'b0;
          end
          retry_d   = cfg_i.max_retries;
          timeout_d = cfg_i.response_timeout;
          status_d  = ST_PENDING;
          error_d   = 1'b0;
          accepted  = 1'b1;
        end
      end
      OP_TICK: begin
        if (status_q == ST_AWAIT && timeout_q != 16'd0) begin
          timeout_d = timeout_q - 16'd1;
        end
      end
      OP_POLL: begin
        if (status_q == ST_PENDING) begin
          send_now = 1'b1;
          if (item_i.link_ok) begin
            status_d = need_ack_q ? ST_AWAIT : ST_FREE;
          end
        end else if (status_q == ST_AWAIT) begin
          if (timeout_q == 16'd0 || error_q) begin
            if (retry_q != 8'd0) begin
              send_now = 1'b1;
              if (item_i.link_ok) begin
                error_d   = 1'b0;
                timeout_d = cfg_i.response_timeout;
                retry_d   = retry_q - 8'd1;
              end
            end else begin
              status_d = ST_FREE;
            end
          end
        end
      end
      OP_RESP: begin
        if (status_q == ST_AWAIT) begin
          if (item_i.resp_code == RESP_OK) begin
            if (item_i.command_code == command_q && item_i.seq_number == seq_q) begin
              status_d = ST_FREE;
            end
          end else if (item_i.resp_code == RESP_ERR) begin
            error_d = 1'b1;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      status_q   <= ST_FREE;
      need_ack_q <= 1'b0;
      retry_q    <= 8'd0;
      timeout_q  <= 16'd0;
      error_q    <= 1'b0;
      func_q     <= 8'd0;
      resp_q     <= 8'd0;
      command_q  <= 8'd0;
      seq_q      <= 16'd0;
      length_q   <= 8'd0;
    end else if (fire_i) begin
      status_q   <= status_d;
      need_ack_q <= need_ack_d;
      retry_q    <= retry_d;
      timeout_q  <= timeout_d;
      error_q    <= error_d;
      func_q     <= func_d;
      resp_q     <= resp_d;
      command_q  <= command_d;
      seq_q      <= seq_d;
      length_q   <= length_d;
    end
  end

  assign result_o.accepted          = accepted;
  assign result_o.send_now          = send_now;
  assign result_o.out_func          = func_d;
  assign result_o.out_resp          = resp_d;
  assign result_o.out_command       = command_d;
  assign result_o.out_seq           = seq_d;
  assign result_o.send_length       = {1'b0, length_d} + {1'b0, cfg_i.header_length};
  assign result_o.buffer_status     = status_d;
  assign result_o.retries_remaining = retry_d;

  a_submit_takes_buffer : assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i && accepted |=> status_q == ST_PENDING)
    else $error("accepted submit did not leave the buffer pending");

  a_send_needs_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    send_now |-> status_q != ST_FREE)
    else $error("send requested while the buffer is free");

  a_state_holds_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !fire_i |=> $stable(status_q) && $stable(timeout_q) && $stable(retry_q))
    else $error("tracker state changed without an item");

endmodule

`default_nettype wire

### src/ack_retransmit_controller.sv
// ============================================================================
// ack_retransmit_controller
// Stop-and-wait transmit tracker for one outgoing packet.
// ============================================================================
// Usage:
//   Items enter on the s_axis group: tuser carries the operation (submit,
//   tick, transmit poll, response) and tdata the header fields. Every item
//   yields exactly one result on the m_axis group with the flags and the
//   stored header after the update.
//   An accepted item is registered in the input register, then processed and
//   placed in the output register once that register is free or draining.
//   A new item is taken every cycle while results keep moving.
//   When m_axis_tready is low the output register holds its result and the
//   input register keeps one item waiting; s_axis_tready then goes low
//   until the output drains.
//   The cfg channel is always ready and writes max_retries, response_timeout
//   and header_length by index; write it only while no item is in flight.
//   Reset frees the buffer, clears the stored header and loads the register
//   defaults of 3 retries, a timeout of 100 ticks and a header of 8 bytes.
// ============================================================================
`default_nettype none

module ack_retransmit_controller (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // [7:0] func_code, [15:8] resp_code, [23:16] command_code,
  // [39:24] seq_number, [47:40] payload_length, [48] link_ok, rest zero
  input  wire logic [55:0] s_axis_tdata,
  // [1:0] operation
  input  wire logic [1:0]  s_axis_tuser,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // [0] accepted, [1] send_now, [9:2] out_func, [17:10] out_resp,
  // [25:18] out_command, [41:26] out_seq, [50:42] send_length,
  // [52:51] buffer_status, [60:53] retries_remaining, rest zero
  output logic [63:0]      m_axis_tdata,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [1:0]  cfg_index_i,
  input  wire logic [15:0] cfg_data_i
);
  import arc_pkg::*;

  arc_cfg_t    cfg;
  arc_item_t   item_q;
  logic        in_valid_q;
  logic        out_valid_q;
  arc_result_t result;
  arc_result_t result_q;
  logic        fire;

  arc_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  assign fire          = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      item_q.operation      <= arc_op_e'(s_axis_tuser);
      item_q.func_code      <= s_axis_tdata[7:0];
      item_q.resp_code      <= s_axis_tdata[15:8];
      item_q.command_code   <= s_axis_tdata[23:16];
      item_q.seq_number     <= s_axis_tdata[39:24];
      item_q.payload_length <= s_axis_tdata[47:40];
      item_q.link_ok        <= s_axis_tdata[48];
    end
  end

  arc_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .fire_i   (fire),
    .item_i   (item_q),
    .cfg_i    (cfg),
    .result_o (result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (fire) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      result_q <= result;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {3'b000,
                          result_q.retries_remaining,
                          result_q.buffer_status,
                          result_q.send_length,
                          result_q.out_seq,
                          result_q.out_command,
                          result_q.out_resp,
                          result_q.out_func,
                          result_q.send_now,
                          result_q.accepted};

endmodule

`default_nettype wire

### sim/tb_ack_retransmit_controller.sv
// ============================================================================
// tb_ack_retransmit_controller
// Self-checking testbench for the stop-and-wait transmit tracker.
// ============================================================================
// A queue of items, filled phase by phase, feeds a clocked driver on the
// s_axis group. Each accepted item runs through a local model of the
// tracker, and the predicted result is queued. A clocked monitor on the
// m_axis group compares every result field by field with the oldest
// prediction. Both sides insert random gaps, the receiver holds off for a
// long stretch twice, and the registers are rewritten between phases
// while nothing is in flight.
// ============================================================================

module tb_ack_retransmit_controller;
  import arc_pkg::*;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [55:0] s_axis_tdata  = '0;
  logic [1:0]  s_axis_tuser  = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [63:0] m_axis_tdata;
  logic        cfg_valid_i   = 1'b0;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i   = '0;
  logic [15:0] cfg_data_i    = '0;

  ack_retransmit_controller u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  arc_item_t   pending_items[$];
  arc_result_t expected_results[$];
  int unsigned items_queued = 0;
  int unsigned items_sent   = 0;
  int unsigned results_seen = 0;
  int unsigned fail_count   = 0;

  // Local copy of the tracker state and its registers.
  arc_cfg_t    mdl_cfg;
  logic [1:0]  mdl_status;
  logic        mdl_need_ack;
  logic [7:0]  mdl_retries;
  logic [15:0] mdl_timer;
  logic        mdl_error;
  logic [7:0]  mdl_func;
  logic [7:0]  mdl_resp;
  logic [7:0]  mdl_command;
  logic [15:0] mdl_seq;
  logic [7:0]  mdl_length;

  // Header of the submit that opened the current stimulus session.
  logic [7:0]  sess_cmd;
  logic [15:0] sess_seq;

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    #4000000;
    $display("ack_retransmit_controller: mismatch");
    $finish;
  end

  task automatic tracker_reset();
    mdl_cfg.max_retries      = RST_MAX_RETRIES;
    mdl_cfg.response_timeout = RST_RESPONSE_TIMEOUT;
    mdl_cfg.header_length    = RST_HEADER_LENGTH;
    mdl_status   = ST_FREE;
    mdl_need_ack = 1'b0;
    mdl_retries  = '0;
    mdl_timer    = '0;
    mdl_error    = 1'b0;
    mdl_func     = '0;
    mdl_resp     = '0;
    mdl_command  = '0;
    mdl_seq      = '0;
    mdl_length   = '0;
  endtask

  function automatic arc_result_t tracker_step(arc_item_t it);
    arc_result_t res;
    res = '0;
    case (it.operation)
      OP_SUBMIT: begin
        if (mdl_status == ST_FREE) begin
          mdl_func    = it.func_code;
          mdl_resp    = it.resp_code;
          mdl_command = it.command_code;
          mdl_seq     = it.seq_number;
          mdl_length  = it.payload_length;
          if (it.func_code == FUNC_ACK_LO || it.func_code == FUNC_ACK_HI) begin
            mdl_need_ack = 1'b1;
          end else if (it.func_code == FUNC_NOACK_LO || it.func_code == FUNC_NOACK_HI) begin
            mdl_need_ack = 1'b0;
          end
          mdl_retries  = mdl_cfg.max_retries;
          mdl_timer    = mdl_cfg.response_timeout;
          mdl_status   = ST_PENDING;
          mdl_error    = 1'b0;
          res.accepted = 1'b1;
        end
      end
      OP_TICK: begin
        if (mdl_status == ST_AWAIT && mdl_timer != 0) begin
          mdl_timer = mdl_timer - 16'd1;
        end
      end
      OP_POLL: begin
        if (mdl_status == ST_PENDING) begin
          res.send_now = 1'b1;
          if (it.link_ok) begin
            mdl_status = mdl_need_ack ? ST_AWAIT : ST_FREE;
          end
        end else if (mdl_status == ST_AWAIT) begin
          if (mdl_timer == 0 || mdl_error) begin
            if (mdl_retries != 0) begin
              res.send_now = 1'b1;
              if (it.link_ok) begin
                mdl_error   = 1'b0;
                mdl_timer   = mdl_cfg.response_timeout;
                mdl_retries = mdl_retries - 8'd1;
              end
            end else begin
              mdl_status = ST_FREE;
            end
          end
        end
      end
      default: begin
        if (mdl_status == ST_AWAIT) begin
          if (it.resp_code == RESP_OK) begin
            if (it.command_code == mdl_command && it.seq_number == mdl_seq) begin
              mdl_status = ST_FREE;
            end
          end else if (it.resp_code == RESP_ERR) begin
            mdl_error = 1'b1;
          end
        end
      end
    endcase
    res.out_func          = mdl_func;
    res.out_resp          = mdl_resp;
    res.out_command       = mdl_command;
    res.out_seq           = mdl_seq;
    res.send_length       = {1'b0, mdl_length} + {1'b0, mdl_cfg.header_length};
    res.buffer_status     = mdl_status;
    res.retries_remaining = mdl_retries;
    return res;
  endfunction

  // Driver: one item in flight on s_axis, random gaps between items.
  arc_item_t   tx_item;
  int unsigned tx_gap  = 0;
  bit          tx_calm = 1'b0;

  always @(posedge clk_i) begin : drive_proc
    bit take_next;
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      take_next = !s_axis_tvalid;
      if (s_axis_tvalid && s_axis_tready) begin
        expected_results.push_back(tracker_step(tx_item));
        items_sent++;
        take_next = 1'b1;
      end
      if (take_next) begin
        if (tx_gap > 0) begin
          tx_gap--;
          s_axis_tvalid <= 1'b0;
        end else if (pending_items.size() != 0) begin
          tx_item = pending_items.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= {7'b0, tx_item.link_ok, tx_item.payload_length,
                            tx_item.seq_number, tx_item.command_code,
                            tx_item.resp_code, tx_item.func_code};
          s_axis_tuser  <= tx_item.operation;
          if ($urandom_range(0, 39) == 0) tx_calm = !tx_calm;
          tx_gap = tx_calm ? 0 : $urandom_range(0, 7);
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  task automatic check_field(string name, logic [15:0] want, logic [15:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      fail_count++;
    end
  endtask

  // Monitor: checks each result and throttles m_axis_tready.
  int unsigned rx_wait = 0;
  bit          rx_calm = 1'b0;

  always @(posedge clk_i) begin : monitor_proc
    arc_result_t want;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        results_seen++;
        if (expected_results.size() == 0) begin
          $error("result %0h arrived with no item waiting for it", m_axis_tdata);
          fail_count++;
        end else begin
          want = expected_results.pop_front();
          check_field("accepted", want.accepted, m_axis_tdata[0]);
          check_field("send_now", want.send_now, m_axis_tdata[1]);
          check_field("out_func", want.out_func, m_axis_tdata[9:2]);
          check_field("out_resp", want.out_resp, m_axis_tdata[17:10]);
          check_field("out_command", want.out_command, m_axis_tdata[25:18]);
          check_field("out_seq", want.out_seq, m_axis_tdata[41:26]);
          check_field("send_length", want.send_length, m_axis_tdata[50:42]);
          check_field("buffer_status", want.buffer_status, m_axis_tdata[52:51]);
          check_field("retries_remaining", want.retries_remaining,
                      m_axis_tdata[60:53]);
          check_field("padding", 16'd0, m_axis_tdata[63:61]);
        end
        if ($urandom_range(0, 39) == 0) rx_calm = !rx_calm;
        if (results_seen == 120 || results_seen == 700) begin
          rx_wait = 200;
        end else begin
          rx_wait = rx_calm ? 0 : $urandom_range(0, 7);
        end
      end
      if (rx_wait > 0) begin
        rx_wait--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  task automatic push_op(arc_op_e op, logic [7:0] func, logic [7:0] resp,
                         logic [7:0] cmd, logic [15:0] seq, logic [7:0] plen,
                         logic link);
    arc_item_t it;
    it.operation      = op;
    it.func_code      = func;
    it.resp_code      = resp;
    it.command_code   = cmd;
    it.seq_number     = seq;
    it.payload_length = plen;
    it.link_ok        = link;
    pending_items.push_back(it);
    items_queued++;
  endtask

  task automatic push_noise(arc_op_e op);
    push_op(op, $urandom_range(0, 255), $urandom_range(0, 255),
            $urandom_range(0, 255), $urandom_range(0, 65535),
            $urandom_range(0, 255), $urandom_range(0, 1));
  endtask

  task automatic push_reply(logic [7:0] resp, logic [7:0] cmd, logic [15:0] seq);
    push_op(OP_RESP, $urandom_range(0, 255), resp, cmd, seq,
            $urandom_range(0, 255), $urandom_range(0, 1));
  endtask

  task automatic push_poll(logic link);
    push_op(OP_POLL, $urandom_range(0, 255), $urandom_range(0, 255),
            $urandom_range(0, 255), $urandom_range(0, 65535),
            $urandom_range(0, 255), link);
  endtask

  // One packet's life: a submit followed by polls, ticks, responses and stray submits.
  task automatic push_session(int unsigned tick_span);
    int unsigned kind;
    logic [7:0]  func;
    kind = $urandom_range(0, 9);
    if (kind < 4) begin
      func = $urandom_range(0, 1) ? FUNC_ACK_LO : FUNC_ACK_HI;
    end else if (kind < 7) begin
      func = $urandom_range(0, 1) ? FUNC_NOACK_LO : FUNC_NOACK_HI;
    end else begin
      func = $urandom_range(0, 255);
    end
    sess_cmd = $urandom_range(0, 255);
    sess_seq = $urandom_range(0, 65535);
    push_op(OP_SUBMIT, func, $urandom_range(0, 255), sess_cmd, sess_seq,
            $urandom_range(0, 255), $urandom_range(0, 1));
    repeat ($urandom_range(2, 10)) begin
      kind = $urandom_range(0, 19);
      if (kind < 7) begin
        push_poll($urandom_range(0, 7) != 0);
      end else if (kind < 11) begin
        repeat ($urandom_range(1, tick_span + 1)) push_noise(OP_TICK);
      end else if (kind < 13) begin
        push_reply(RESP_ERR, $urandom_range(0, 255), $urandom_range(0, 65535));
      end else if (kind < 15) begin
        push_reply(RESP_OK, sess_cmd, sess_seq);
      end else if (kind < 16) begin
        if ($urandom_range(0, 1)) begin
          push_reply(RESP_OK, sess_cmd ^ (8'd1 << $urandom_range(0, 7)), sess_seq);
        end else begin
          push_reply(RESP_OK, sess_cmd, sess_seq ^ (16'd1 << $urandom_range(0, 15)));
        end
      end else if (kind < 17) begin
        push_noise(OP_RESP);
      end else if (kind < 18) begin
        push_noise(OP_SUBMIT);
      end else begin
        push_poll(1'b1);
      end
    end
    if ($urandom_range(0, 9) < 6) begin
      push_poll(1'b1);
      push_reply(RESP_OK, sess_cmd, sess_seq);
    end
  endtask

  task automatic wait_drained();
    while (items_sent != items_queued || expected_results.size() != 0) begin
      @(posedge clk_i);
    end
  endtask

  task automatic cfg_write(logic [1:0] idx, logic [15:0] val);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    case (idx)
      CFG_MAX_RETRIES:      mdl_cfg.max_retries = val[7:0];
      CFG_RESPONSE_TIMEOUT: mdl_cfg.response_timeout = val;
      CFG_HEADER_LENGTH:    mdl_cfg.header_length = val[7:0];
      default: ;
    endcase
  endtask

  task automatic set_config(logic [7:0] retries, logic [15:0] timeout,
                            logic [7:0] hdr_len);
    wait_drained();
    repeat (4) @(posedge clk_i);
    cfg_write(CFG_MAX_RETRIES, {8'd0, retries});
    cfg_write(CFG_RESPONSE_TIMEOUT, timeout);
    cfg_write(CFG_HEADER_LENGTH, {8'd0, hdr_len});
  endtask

  task automatic run_phase(logic [7:0] retries, logic [15:0] timeout,
                           logic [7:0] hdr_len, int unsigned count);
    int unsigned stop_at;
    int unsigned span;
    set_config(retries, timeout, hdr_len);
    span    = (timeout > 12) ? 12 : timeout;
    stop_at = items_queued + count;
    while (items_queued < stop_at) begin
      if ($urandom_range(0, 99) < 15) begin
        push_noise(arc_op_e'($urandom_range(0, 3)));
      end else begin
        push_session(span);
      end
    end
  endtask

  initial begin
    tracker_reset();
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Default registers: full header, busy submit, failed send, error resend.
    push_op(OP_SUBMIT, FUNC_ACK_LO, 8'hFF, 8'hA5, 16'hFFFF, 8'hFF, 1'b0);
    push_op(OP_SUBMIT, FUNC_NOACK_LO, 8'h00, 8'h00, 16'h0000, 8'h00, 1'b1);
    push_op(OP_POLL, 8'h00, 8'h00, 8'h00, 16'h0000, 8'h00, 1'b0);
    push_op(OP_POLL, 8'h00, 8'h00, 8'h00, 16'h0000, 8'h00, 1'b1);
    push_op(OP_TICK, 8'hFF, 8'hFF, 8'hFF, 16'hFFFF, 8'hFF, 1'b1);
    push_op(OP_TICK, 8'h00, 8'h00, 8'h00, 16'h0000, 8'h00, 1'b0);
    push_op(OP_RESP, 8'h00, RESP_OK, 8'h5A, 16'hFFFF, 8'h00, 1'b0);
    push_op(OP_RESP, 8'h00, 8'h55, 8'hA5, 16'hFFFF, 8'h00, 1'b0);
    push_op(OP_RESP, 8'h00, RESP_ERR, 8'h00, 16'h0000, 8'h00, 1'b0);
    push_op(OP_POLL, 8'h00, 8'h00, 8'h00, 16'h0000, 8'h00, 1'b1);
    push_op(OP_POLL, 8'h00, 8'h00, 8'h00, 16'h0000, 8'h00, 1'b1);
    push_op(OP_RESP, 8'h00, RESP_OK, 8'hA5, 16'hFFFF, 8'h00, 1'b1);
    push_op(OP_RESP, 8'h00, RESP_ERR, 8'hA5, 16'hFFFF, 8'h00, 1'b1);
    push_op(OP_TICK, 8'h00, 8'h00, 8'h00, 16'h0000, 8'h00, 1'b0);
    push_op(OP_SUBMIT, FUNC_NOACK_HI, 8'h00, 8'h00, 16'h0000, 8'h00, 1'b0);
    push_op(OP_POLL, 8'h00, 8'h00, 8'h00, 16'h0000, 8'h00, 1'b1);
    push_op(OP_SUBMIT, 8'h80, 8'h11, 8'h22, 16'h3344, 8'h55, 1'b0);
    push_op(OP_POLL, 8'h00, 8'h00, 8'h00, 16'h0000, 8'h00, 1'b1);
    push_op(OP_SUBMIT, FUNC_ACK_HI, 8'h01, 8'h3C, 16'h1234, 8'h10, 1'b0);
    push_op(OP_POLL, 8'h00, 8'h00, 8'h00, 16'h0000, 8'h00, 1'b1);
    push_op(OP_RESP, 8'h00, RESP_OK, 8'h3C, 16'h1234, 8'h00, 1'b0);
    push_op(OP_SUBMIT, 8'hFF, 8'h02, 8'h77, 16'h8001, 8'h01, 1'b0);
    push_op(OP_POLL, 8'h00, 8'h00, 8'h00, 16'h0000, 8'h00, 1'b1);

    // No retries, one-tick timeout: tick at zero and release on expiry.
    set_config(8'd0, 16'd1, 8'd255);
    push_op(OP_RESP, 8'h00, RESP_OK, 8'h77, 16'h8001, 8'h00, 1'b0);
    push_op(OP_SUBMIT, FUNC_ACK_LO, 8'h00, 8'h01, 16'h0001, 8'h80, 1'b0);
    push_op(OP_POLL, 8'h00, 8'h00, 8'h00, 16'h0000, 8'h00, 1'b1);
    push_op(OP_TICK, 8'h00, 8'h00, 8'h00, 16'h0000, 8'h00, 1'b0);
    push_op(OP_TICK, 8'h00, 8'h00, 8'h00, 16'h0000, 8'h00, 1'b0);
    push_op(OP_POLL, 8'h00, 8'h00, 8'h00, 16'h0000, 8'h00, 1'b1);

    run_phase(8'd3, 16'd5, 8'd8, 210);
    run_phase(8'd0, 16'd1, 8'd0, 210);
    run_phase(8'd255, 16'd2, 8'd255, 210);
    run_phase(8'd1, 16'd65535, 8'd17, 210);
    run_phase(8'd7, 16'd0, 8'd100, 210);
    run_phase($urandom_range(0, 10), $urandom_range(1, 12), $urandom_range(0, 255), 210);
    run_phase($urandom_range(0, 10), $urandom_range(1, 12), $urandom_range(0, 255), 210);

    wait_drained();
    repeat (20) @(posedge clk_i);
    if (fail_count == 0 && expected_results.size() == 0) begin
      $display("ack_retransmit_controller: match");
    end else begin
      $display("ack_retransmit_controller: mismatch");
    end
    $finish;
  end

endmodule
